// File: rtl/assert_macros.svh
// Shared assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/phsi_pkg.sv
package phsi_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 12;
  localparam int PTR_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int ADDR_SUM_W  = PTR_W + 1;
  localparam int COUNT_OUT_W = 7;
  localparam int MODE_W      = 2;
  localparam int IN_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((2 + COUNT_OUT_W + 7) / 8) * 8;
  localparam int SEG_LAT     = 3;
  localparam int DRAIN_W     = $clog2(SEG_LAT + 1);
  localparam int MIN_CROSS_COUNT = 5;

  localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GROW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef enum logic [1:0] {
    OP_MOVE,
    OP_GROW,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t    op;
    point_t pt;
  } cmd_t;

  typedef enum logic [1:0] {
    ORI_COL,
    ORI_CW,
    ORI_CCW
  } orient_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // Wrap a logical point index onto the circular store.
  function automatic logic [PTR_W-1:0] wrap_addr(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] k);
    logic [ADDR_SUM_W-1:0] s;
    s = ADDR_SUM_W'(head) + ADDR_SUM_W'(k);
    if (s >= ADDR_SUM_W'(MAX_POINTS)) begin
      s = s - ADDR_SUM_W'(MAX_POINTS);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/phsi_ram.sv
module phsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/phsi_front.sv
module phsi_front import phsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [MODE_W-1:0]    s_tuser,
  output logic                 q_valid,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    case (s_tuser)
      MODE_MOVE:  cmd_in.op = OP_MOVE;
      MODE_GROW:  cmd_in.op = OP_GROW;
      MODE_CLEAR: cmd_in.op = OP_CLEAR;
      default:    cmd_in.op = OP_NONE;
    endcase
    cmd_in.pt.x = s_tdata[COORD_BITS-1:0];
    cmd_in.pt.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// File: rtl/phsi_seg.sv
module phsi_seg import phsi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  point_t a,
  input  point_t b,
  input  point_t c,
  input  point_t d,
  output logic   hit_valid,
  output logic   hit
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;

  point_t ta [4];
  point_t tb [4];
  point_t tc [4];

  diff_t u1 [4];
  diff_t v1 [4];
  diff_t u2 [4];
  diff_t v2 [4];
  logic [3:0] win;

  diff_t u1_q [4];
  diff_t v1_q [4];
  diff_t u2_q [4];
  diff_t v2_q [4];
  logic [3:0] win_q;
  prod_t pa_q [4];
  prod_t pb_q [4];
  logic [3:0] win_qq;
  logic [1:0] vld;

  orient_t ori [4];
  logic signed [PW:0] det [4];
  logic hit_next;

  function automatic logic in_box(input point_t p, input point_t q, input point_t r);
    coord_t lox, hix, loy, hiy;
    lox = (p.x < r.x) ? p.x : r.x;
    hix = (p.x < r.x) ? r.x : p.x;
    loy = (p.y < r.y) ? p.y : r.y;
    hiy = (p.y < r.y) ? r.y : p.y;
    return (q.x >= lox) && (q.x <= hix) && (q.y >= loy) && (q.y <= hiy);
  endfunction

  always_comb begin
    ta[0] = a; tb[0] = b; tc[0] = c;
    ta[1] = a; tb[1] = b; tc[1] = d;
    ta[2] = c; tb[2] = d; tc[2] = a;
    ta[3] = c; tb[3] = d; tc[3] = b;
    for (int j = 0; j < 4; j++) begin
      u1[j] = DW'(tb[j].y) - DW'(ta[j].y);
      v1[j] = DW'(tc[j].x) - DW'(tb[j].x);
      u2[j] = DW'(tb[j].x) - DW'(ta[j].x);
      v2[j] = DW'(tc[j].y) - DW'(tb[j].y);
    end
    win[0] = in_box(a, c, b);
    win[1] = in_box(a, d, b);
    win[2] = in_box(c, a, d);
    win[3] = in_box(c, b, d);
  end

  // Stage 1: differences, stage 2: products, stage 3: sign and decision.
  always_ff @(posedge clk) begin
    u1_q  <= u1;
    v1_q  <= v1;
    u2_q  <= u2;
    v2_q  <= v2;
    win_q <= win;
    for (int j = 0; j < 4; j++) begin
      pa_q[j] <= PW'(u1_q[j]) * PW'(v1_q[j]);
      pb_q[j] <= PW'(u2_q[j]) * PW'(v2_q[j]);
    end
    win_qq <= win_q;
    hit    <= hit_next;
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      det[j] = (PW + 1)'(pa_q[j]) - (PW + 1)'(pb_q[j]);
      if (det[j] == '0) begin
        ori[j] = ORI_COL;
      end else if (det[j] > 0) begin
        ori[j] = ORI_CW;
      end else begin
        ori[j] = ORI_CCW;
      end
    end
    hit_next = ((ori[0] != ori[1]) && (ori[2] != ori[3])) ||
               ((ori[0] == ORI_COL) && win_qq[0]) ||
               ((ori[1] == ORI_COL) && win_qq[1]) ||
               ((ori[2] == ORI_COL) && win_qq[2]) ||
               ((ori[3] == ORI_COL) && win_qq[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      hit_valid <= 1'b0;
    end else begin
      vld       <= {vld[0], in_valid};
      hit_valid <= vld[1];
    end
  end

endmodule

// File: rtl/phsi_back.sv
module phsi_back import phsi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  state_t state, state_next;

  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ri;
  logic [DRAIN_W-1:0] drain;
  logic               hit_acc;
  point_t             p0, p1, prev;
  logic               rd_valid;
  logic [CNT_W-1:0]   rd_tag;

  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [PTR_W-1:0]   ram_raddr;
  point_t             ram_rdata;
  logic               rd_issue;
  logic [CNT_W-1:0]   rd_issue_tag;
  logic [PTR_W-1:0]   head_dec;

  logic               seg_in_valid;
  logic               seg_hit_valid;
  logic               seg_hit;

  logic               load_out;
  logic               out_crossed;
  logic               out_dropped;
  logic [CNT_W-1:0]   out_count;
  logic               start;

  assign head_dec = (head == '0) ? PTR_W'(MAX_POINTS - 1) : head - 1'b1;
  assign start    = (state == ST_IDLE) && q_valid && !m_tvalid;

  phsi_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_cmd.pt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign seg_in_valid = rd_valid && (rd_tag >= CNT_W'(4));

  phsi_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_in_valid),
    .a         (p0),
    .b         (p1),
    .c         (prev),
    .d         (ram_rdata),
    .hit_valid (seg_hit_valid),
    .hit       (seg_hit)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (q_cmd.op == OP_MOVE) &&
            (count >= CNT_W'(MIN_CROSS_COUNT))) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ri == count - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = head_dec;
    ram_raddr    = wrap_addr(head, ri);
    rd_issue     = 1'b0;
    rd_issue_tag = ri;
    load_out     = 1'b0;
    out_crossed  = 1'b0;
    out_dropped  = 1'b0;
    out_count    = count;
    case (state)
      ST_IDLE: begin
        if (start) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_MOVE: begin
              ram_we       = (count != '0);
              ram_raddr    = head;
              rd_issue     = 1'b1;
              rd_issue_tag = CNT_W'(1);
              load_out     = (count < CNT_W'(MIN_CROSS_COUNT));
            end
            OP_GROW: begin
              load_out = 1'b1;
              if (count < CNT_W'(MAX_POINTS)) begin
                ram_we    = 1'b1;
                ram_waddr = wrap_addr(head, count);
                out_count = count + 1'b1;
              end else begin
                out_dropped = 1'b1;
              end
            end
            OP_CLEAR: begin
              load_out  = 1'b1;
              out_count = '0;
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        rd_issue = 1'b1;
      end
      ST_DRAIN: begin
        load_out    = (drain == '0);
        out_crossed = hit_acc || (seg_hit_valid && seg_hit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && (q_cmd.op == OP_MOVE)) begin
      p0 <= q_cmd.pt;
    end
    if (rd_valid) begin
      if (rd_tag == CNT_W'(1)) begin
        p1 <= ram_rdata;
      end else begin
        prev <= ram_rdata;
      end
    end
    rd_tag <= rd_issue_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      ri       <= '0;
      drain    <= '0;
      hit_acc  <= 1'b0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_issue;
      if (start && (q_cmd.op == OP_MOVE)) begin
        if (count != '0) begin
          head <= head_dec;
        end
        ri      <= CNT_W'(3);
        hit_acc <= 1'b0;
      end else if (state == ST_SCAN) begin
        ri <= ri + 1'b1;
      end
      if (state == ST_SCAN) begin
        drain <= DRAIN_W'(SEG_LAT);
      end else if (state == ST_DRAIN) begin
        drain <= drain - 1'b1;
      end
      if (seg_hit_valid && seg_hit) begin
        hit_acc <= 1'b1;
      end
      // Hold the result until the downstream side takes it.
      if (load_out) begin
        count    <= out_count;
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_DATA_W'({out_dropped, COUNT_OUT_W'(out_count), out_crossed});
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/polyline_head_self_intersect.sv
// Polyline head self-intersection checker.
// Input channel s_*: one transaction per command. s_tuser carries the mode
// (move head, append at tail, clear, other codes do nothing); s_tdata carries
// the new point. Output channel m_*: exactly one transaction per command with
// the crossed flag, the point count after the command and the dropped flag.
// Points sit in a circular store (one write and one registered read per
// cycle); a move on a non-empty store steps the head back and writes the new
// head. A two-entry command queue sits between input stage and executor.
// Path: append, clear, unused codes and moves on fewer than five points
// are decided by the executor alone and registered into the output
// register; a move on N >= 5 points first has the store's single read port
// walk points 1 and 3..N-1 one per cycle, then the three-stage orientation
// test. Commands run one at a time.
// A new command starts only once the previous result has been taken.
// Reset clears the queue, the point count and the output valid; store
// contents are not cleared and are never used before being written.
// When the receiver stalls the result holds in the output register, the
// executor waits, and the queue keeps accepting until its two entries fill.
module polyline_head_self_intersect import phsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y
  input  logic [MODE_W-1:0]     s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // crossed, point_count, dropped
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  phsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  phsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: rtl/phsi_checker.sv
`include "assert_macros.svh"

module phsi_checker import phsi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [MODE_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic [COUNT_OUT_W-1:0] cnt;
  assign cnt = m_tdata[COUNT_OUT_W:1];

  `CHK_IMPL(a_count_max, m_tvalid, cnt <= COUNT_OUT_W'(MAX_POINTS), "count above store size")
  `CHK_IMPL(a_drop_full, m_tvalid && m_tdata[COUNT_OUT_W+1], cnt == COUNT_OUT_W'(MAX_POINTS) && !m_tdata[0], "drop while not full")
  `CHK_IMPL(a_cross_len, m_tvalid && m_tdata[0], cnt >= COUNT_OUT_W'(MIN_CROSS_COUNT), "cross on short line")
  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind polyline_head_self_intersect phsi_checker u_chk (.*);
